// ===== hw/rtl/fcd_pkg.sv =====
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types and constants for the flock cohesion direction block.
// ----------------------------------------------------------------------------
package fcd_pkg;

    localparam int POS_W      = 32;
    localparam int VEC_W      = 16;
    localparam int SPD_W      = 16;
    localparam int TIME_W     = 32;
    localparam int DIST_W     = 24;
    localparam int DIRZ_W     = 15;
    localparam int DIV_W      = 48;      // (product + half) >> 17, three digits
    localparam int DIGIT_W    = 16;      // quotient digit per divide step
    localparam int DIV_STEPS  = DIV_W / DIGIT_W;
    localparam int TRIAL_W    = 23;      // 7-bit remainder + one digit
    localparam int RCP_W      = TRIAL_W + 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [23:0] DIV_RECIP = 24'd8589935;  // ceil(2^30 / 125)
    localparam int CNT_W      = 2;
    localparam int DIV_SHIFT  = 17;      // 16384000 = 2^17 * 125
    localparam logic [63:0] ROUND_HALF = 64'd8192000;
    localparam logic [7:0]  DIV_ODD    = 8'd125;
    localparam logic [DIRZ_W-1:0] UP_Z = 15'd16384;
    localparam logic [14:0] UNIT_MAG   = 15'd16384;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 24'd12800;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic prep;
        logic div_step;
        logic offset;
        logic test;
        logic acc;
        logic ninit;
        logic nsq;
        logic ncmp;
        logic nstore;
        logic out_load;
        logic sel;       // 0: x component, 1: y component
    } fcd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic port_mode;
        logic port_last;
        logic item_last;
        logic search_open;
    } fcd_stat_t;

endpackage

// ===== hw/rtl/fcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcd_ctrl
// Sequencer: neighbor extrapolation steps, normalization search, output.
// ----------------------------------------------------------------------------
module fcd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  fcd_pkg::fcd_stat_t st,
    output fcd_pkg::fcd_cmd_t  cmd
);
    import fcd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_PREP, S_DIV, S_OFF, S_TEST, S_ACC,
        S_NINIT, S_NSQ, S_NCMP, S_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sel_reg, sel_next;
    logic             ov_reg, ov_next;
    logic             out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_free  = !ov_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        cmd.sel    = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (st.port_mode)
                        state_next = S_MUL;
                    else if (st.port_last)
                    begin
                        sel_next   = 1'b0;
                        state_next = S_NINIT;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_OFF;
            end
            S_OFF:
            begin
                cmd.offset = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                cmd.test   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc  = 1'b1;
                sel_next = 1'b0;
                state_next = st.item_last ? S_NINIT : S_IDLE;
            end
            S_NINIT:
            begin
                cmd.ninit  = 1'b1;
                state_next = S_NSQ;
            end
            S_NSQ:
            begin
                if (st.search_open)
                begin
                    cmd.nsq    = 1'b1;
                    state_next = S_NCMP;
                end
                else
                begin
                    cmd.nstore = 1'b1;
                    if (!sel_reg)
                    begin
                        sel_next   = 1'b1;
                        state_next = S_NINIT;
                    end
                    else
                        state_next = S_OUT;
                end
            end
            S_NCMP:
            begin
                cmd.ncmp   = 1'b1;
                state_next = S_NSQ;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ===== hw/rtl/fcd_dp.sv =====
// ----------------------------------------------------------------------------
// fcd_dp
// Datapath: ego state, extrapolation, neighbor test, sum, normalization.
// ----------------------------------------------------------------------------
module fcd_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  fcd_pkg::fcd_cmd_t                 cmd,
    output fcd_pkg::fcd_stat_t                st,
    input  logic                              cfg_wr_en,
    input  logic [fcd_pkg::DIST_W-1:0]        cfg_wr_data,
    input  logic                              mode,
    input  logic signed [fcd_pkg::POS_W-1:0]  pos_x,
    input  logic signed [fcd_pkg::POS_W-1:0]  pos_y,
    input  logic signed [fcd_pkg::VEC_W-1:0]  fwd_x,
    input  logic signed [fcd_pkg::VEC_W-1:0]  fwd_y,
    input  logic signed [fcd_pkg::VEC_W-1:0]  fwd_z,
    input  logic [fcd_pkg::SPD_W-1:0]         speed,
    input  logic [fcd_pkg::TIME_W-1:0]        stamp,
    input  logic                              last,
    output logic signed [fcd_pkg::VEC_W-1:0]  dir_x,
    output logic signed [fcd_pkg::VEC_W-1:0]  dir_y,
    output logic [fcd_pkg::DIRZ_W-1:0]        dir_z
);
    import fcd_pkg::*;

    // control-like state (reset)
    logic [DIST_W-1:0]       md_reg;
    logic signed [POS_W-1:0] ego_x_reg, ego_y_reg;
    logic signed [VEC_W-1:0] ef0_reg, ef1_reg, ef2_reg;
    logic [TIME_W-1:0]       now_reg;
    logic signed [63:0]      sum_reg;
    logic [15:0]             mc_reg;

    // item and work registers
    logic signed [POS_W-1:0] px_reg, py_reg;
    logic signed [VEC_W-1:0] fx_reg, fy_reg, fz_reg;
    logic                    last_reg, fnx_reg, fny_reg, age_neg_reg;
    logic [31:0]             age_mag_reg, fsx_reg, fsy_reg;
    logic [63:0]             mx_reg, my_reg;
    logic [DIV_W-1:0]        qx_reg, qy_reg;
    logic [6:0]              rx7_reg, ry7_reg;
    logic signed [47:0]      dx_reg, dy_reg;
    logic signed [33:0]      fdot_reg;
    logic                    ok_reg;
    logic [50:0]             d2_reg;
    logic [47:0]             r2_reg;
    logic signed [43:0]      proj_reg;
    logic [31:0]             l2_reg;
    logic [61:0]             rhs_reg;
    logic [29:0]             tsq_reg;
    logic [14:0]             lo_reg, hi_reg, mid_reg;
    logic                    cneg_reg;
    logic signed [VEC_W-1:0] rx_reg, ry_reg;
    logic signed [VEC_W-1:0] ox_reg, oy_reg;
    logic [DIRZ_W-1:0]       oz_reg;

    // combinational terms
    logic [32:0]             age_diff;
    logic [15:0]             abs_fx, abs_fy;
    logic [TRIAL_W-1:0]      trial_x, trial_y;
    logic [RCP_W-1:0]        rcp_x, rcp_y;
    logic [DIGIT_W-1:0]      dig_x, dig_y;
    logic [TRIAL_W-1:0]      rem_x, rem_y;
    logic signed [47:0]      shx, shy;
    logic signed [25:0]      dx26, dy26;
    logic signed [16:0]      nef1, comp;
    logic signed [42:0]      p1, p2;
    logic                    in_rng;
    logic signed [64:0]      s65;
    logic signed [63:0]      sum_sat;
    logic [15:0]             comp_mag;
    logic [15:0]             mid_sum;
    logic [14:0]             mid_v, t_v;
    logic [61:0]             prod;
    logic signed [32:0]      l2_w;
    logic signed [VEC_W-1:0] store_v;

    assign age_diff = {1'b0, now_reg} - {1'b0, stamp};
    assign abs_fx   = fwd_x[VEC_W-1] ? 16'(-fwd_x) : 16'(fwd_x);
    assign abs_fy   = fwd_y[VEC_W-1] ? 16'(-fwd_y) : 16'(fwd_y);
    // divide by 125 one 16-bit digit at a time: reciprocal multiply, then
    // the remainder carries into the next digit
    assign trial_x  = {rx7_reg, qx_reg[DIV_W-1 -: DIGIT_W]};
    assign trial_y  = {ry7_reg, qy_reg[DIV_W-1 -: DIGIT_W]};
    assign rcp_x    = RCP_W'(trial_x) * RCP_W'(DIV_RECIP);
    assign rcp_y    = RCP_W'(trial_y) * RCP_W'(DIV_RECIP);
    assign dig_x    = rcp_x[RECIP_SHIFT +: DIGIT_W];
    assign dig_y    = rcp_y[RECIP_SHIFT +: DIGIT_W];
    assign rem_x    = trial_x - TRIAL_W'(dig_x) * TRIAL_W'(DIV_ODD);
    assign rem_y    = trial_y - TRIAL_W'(dig_y) * TRIAL_W'(DIV_ODD);
    assign shx = (fnx_reg ^ age_neg_reg) ? -48'(qx_reg) : 48'(qx_reg);
    assign shy = (fny_reg ^ age_neg_reg) ? -48'(qy_reg) : 48'(qy_reg);
    assign dx26 = dx_reg[25:0];
    assign dy26 = dy_reg[25:0];
    assign nef1 = -17'(ef1_reg);
    assign p1   = dx26 * nef1;
    assign p2   = dy26 * 17'(ef0_reg);
    assign in_rng = (dx_reg > -48'sd33554432) && (dx_reg < 48'sd33554432) &&
                    (dy_reg > -48'sd33554432) && (dy_reg < 48'sd33554432) &&
                    (fdot_reg > 34'sd0);
    assign s65 = 65'(sum_reg) + 65'(proj_reg);
    assign sum_sat = (s65[64] != s65[63]) ?
                     (s65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : s65[63:0];
    assign comp = cmd.sel ? 17'(ef0_reg) : nef1;
    assign comp_mag = comp[16] ? 16'(-comp) : 16'(comp);
    assign l2_w = 33'(ef0_reg * ef0_reg) + 33'(ef1_reg * ef1_reg);
    assign mid_sum = 16'(lo_reg) + 16'(hi_reg) + 16'd1;
    assign mid_v = mid_sum[15:1];
    assign t_v   = 15'({mid_v, 1'b0} - 16'd1);
    assign prod  = 62'(tsq_reg) * 62'(l2_reg);
    assign store_v = (cneg_reg ^ sum_reg[63]) ? -16'(lo_reg) : 16'(lo_reg);

    assign st.port_mode   = mode;
    assign st.port_last   = last;
    assign st.item_last   = last_reg;
    assign st.search_open = (lo_reg < hi_reg);

    assign dir_x = ox_reg;
    assign dir_y = oy_reg;
    assign dir_z = oz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            md_reg    <= MAX_DIST_RST;
            ego_x_reg <= '0;
            ego_y_reg <= '0;
            ef0_reg   <= '0;
            ef1_reg   <= '0;
            ef2_reg   <= '0;
            now_reg   <= '0;
            sum_reg   <= '0;
            mc_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                md_reg <= cfg_wr_data;
            if (cmd.accept && !mode)
            begin
                ego_x_reg <= pos_x;
                ego_y_reg <= pos_y;
                ef0_reg   <= fwd_x;
                ef1_reg   <= fwd_y;
                ef2_reg   <= fwd_z;
                now_reg   <= stamp;
                sum_reg   <= '0;
                mc_reg    <= '0;
            end
            else if (cmd.acc && ok_reg && (51'(d2_reg) < 51'(r2_reg)))
            begin
                sum_reg <= sum_sat;
                if (mc_reg != 16'hFFFF)
                    mc_reg <= mc_reg + 16'd1;
            end
            else if (cmd.out_load)
            begin
                sum_reg <= '0;
                mc_reg  <= '0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg      <= pos_x;
            py_reg      <= pos_y;
            fx_reg      <= fwd_x;
            fy_reg      <= fwd_y;
            fz_reg      <= fwd_z;
            last_reg    <= last;
            fnx_reg     <= fwd_x[VEC_W-1];
            fny_reg     <= fwd_y[VEC_W-1];
            age_neg_reg <= age_diff[32];
            age_mag_reg <= age_diff[32] ? 32'(-age_diff) : age_diff[31:0];
            fsx_reg     <= abs_fx * speed;
            fsy_reg     <= abs_fy * speed;
        end
        if (cmd.mul)
        begin
            mx_reg <= 64'(fsx_reg) * 64'(age_mag_reg);
            my_reg <= 64'(fsy_reg) * 64'(age_mag_reg);
        end
        if (cmd.prep)
        begin
            qx_reg  <= DIV_W'((mx_reg + ROUND_HALF) >> DIV_SHIFT);
            qy_reg  <= DIV_W'((my_reg + ROUND_HALF) >> DIV_SHIFT);
            rx7_reg <= '0;
            ry7_reg <= '0;
        end
        // division by 125, one 16-bit quotient digit per lane per cycle
        if (cmd.div_step)
        begin
            rx7_reg <= rem_x[6:0];
            ry7_reg <= rem_y[6:0];
            qx_reg  <= {qx_reg[DIV_W-DIGIT_W-1:0], dig_x};
            qy_reg  <= {qy_reg[DIV_W-DIGIT_W-1:0], dig_y};
        end
        if (cmd.offset)
        begin
            dx_reg   <= 48'(px_reg) + shx - 48'(ego_x_reg);
            dy_reg   <= 48'(py_reg) + shy - 48'(ego_y_reg);
            fdot_reg <= 34'(ef0_reg * fx_reg) + 34'(ef1_reg * fy_reg) +
                        34'(ef2_reg * fz_reg);
        end
        if (cmd.test)
        begin
            ok_reg   <= in_rng;
            d2_reg   <= 51'(50'(dx26 * dx26)) + 51'(50'(dy26 * dy26));
            r2_reg   <= 48'(md_reg) * 48'(md_reg);
            proj_reg <= 44'(p1) + 44'(p2);
        end
        if (cmd.ninit)
        begin
            l2_reg   <= l2_w[31:0];
            rhs_reg  <= {32'(comp_mag) * 32'(comp_mag), 30'd0};
            cneg_reg <= comp[16];
            lo_reg   <= '0;
            hi_reg   <= UNIT_MAG;
        end
        if (cmd.nsq)
        begin
            mid_reg <= mid_v;
            tsq_reg <= 30'(t_v) * 30'(t_v);
        end
        if (cmd.ncmp)
        begin
            if (prod <= rhs_reg)
                lo_reg <= mid_reg;
            else
                hi_reg <= mid_reg - 15'd1;
        end
        if (cmd.nstore)
        begin
            if (cmd.sel)
                ry_reg <= store_v;
            else
                rx_reg <= store_v;
        end
        if (cmd.out_load)
        begin
            if (mc_reg == '0)
            begin
                ox_reg <= '0;
                oy_reg <= '0;
                oz_reg <= UP_Z;
            end
            else if ((sum_reg == '0) || (l2_reg == '0))
            begin
                ox_reg <= '0;
                oy_reg <= '0;
                oz_reg <= '0;
            end
            else
            begin
                ox_reg <= rx_reg;
                oy_reg <= ry_reg;
                oz_reg <= '0;
            end
        end
    end

endmodule

// ===== hw/rtl/flock_cohesion_direction.sv =====
// ----------------------------------------------------------------------------
// flock_cohesion_direction
// Cohesion steering direction from an ego item and a stream of neighbors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction per item. A job
//   starts with an ego item (mode 0) and continues with neighbor items
//   (mode 1); the item with last set closes the job and yields one result.
//   Output channel (out_valid / out_stall): one transaction per job, giving
//   dir_x, dir_y (Q1.14) and dir_z (16384 for the up vector, else 0).
//   cfg_wr_en / cfg_wr_data write max_distance; write only while idle.
// Steps:
//   An ego item without last leaves the block idle. A neighbor item runs
//   accept with the speed multiply, the age multiply, rounding, the
//   divide by 125 (one 16-bit digit per cycle by reciprocal multiply),
//   then offset, test and accumulate.
//   Closing a job adds the normalization search: per component a setup
//   step, up to 15 binary-search steps of square then compare, and a
//   store; the output is then loaded once the output register is free.
// Reset: control state cleared, max_distance = 12800, no result pending.
// Stall: a result waits in the output register; the next job's items are
//   taken meanwhile, and only the next result waits until that one leaves.
// ----------------------------------------------------------------------------
module flock_cohesion_direction
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [fcd_pkg::DIST_W-1:0]        cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic signed [fcd_pkg::POS_W-1:0]  pos_x,
    input  logic signed [fcd_pkg::POS_W-1:0]  pos_y,
    input  logic signed [fcd_pkg::VEC_W-1:0]  fwd_x,
    input  logic signed [fcd_pkg::VEC_W-1:0]  fwd_y,
    input  logic signed [fcd_pkg::VEC_W-1:0]  fwd_z,
    input  logic [fcd_pkg::SPD_W-1:0]         speed,
    input  logic [fcd_pkg::TIME_W-1:0]        stamp,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [fcd_pkg::VEC_W-1:0]  dir_x,
    output logic signed [fcd_pkg::VEC_W-1:0]  dir_y,
    output logic [fcd_pkg::DIRZ_W-1:0]        dir_z
);
    import fcd_pkg::*;

    fcd_cmd_t  cmd;
    fcd_stat_t st;

    // sequencer: owns handshake and step order
    fcd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // arithmetic and state
    fcd_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mode        (mode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .fwd_x       (fwd_x),
        .fwd_y       (fwd_y),
        .fwd_z       (fwd_z),
        .speed       (speed),
        .stamp       (stamp),
        .last        (last),
        .dir_x       (dir_x),
        .dir_y       (dir_y),
        .dir_z       (dir_z)
    );

endmodule

// ===== hw/rtl/fcd_checker.sv =====
// ----------------------------------------------------------------------------
// fcd_checker
// Port-level checks for the flock cohesion direction block.
// ----------------------------------------------------------------------------
module fcd_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              mode,
    input logic                              last,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [fcd_pkg::VEC_W-1:0]  dir_x,
    input logic signed [fcd_pkg::VEC_W-1:0]  dir_y,
    input logic [fcd_pkg::DIRZ_W-1:0]        dir_z
);
    import fcd_pkg::*;

    // pending result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dir_x) &&
        $stable(dir_y) && $stable(dir_z))
        else $error("result changed while stalled");

    // up vector carries no horizontal part
    a_up_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (dir_z != '0) |-> (dir_z == UP_Z) && (dir_x == '0) &&
        (dir_y == '0))
        else $error("malformed up vector");

    // horizontal result stays within unit range
    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dir_x >= -16'sd16384) && (dir_x <= 16'sd16384) &&
        (dir_y >= -16'sd16384) && (dir_y <= 16'sd16384))
        else $error("direction out of range");

    // a neighbor keeps the block busy for the next cycle
    a_nbr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode |=> in_stall)
        else $error("neighbor did not occupy the block");

    // an item that does not close a job cannot produce a result at once
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !last && !out_valid |=> !out_valid)
        else $error("result without a closing item");

endmodule

bind flock_cohesion_direction fcd_checker u_fcd_checker (.*);

// ===== dv/flock_cohesion_direction_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flock_cohesion_direction_checker
// Watches the item and result channels, predicts each job's steering
// direction and compares it with what the block returns.
// ----------------------------------------------------------------------------
module flock_cohesion_direction_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [fcd_pkg::DIST_W-1:0]        cfg_wr_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              mode,
    input  logic signed [fcd_pkg::POS_W-1:0]  pos_x,
    input  logic signed [fcd_pkg::POS_W-1:0]  pos_y,
    input  logic signed [fcd_pkg::VEC_W-1:0]  fwd_x,
    input  logic signed [fcd_pkg::VEC_W-1:0]  fwd_y,
    input  logic signed [fcd_pkg::VEC_W-1:0]  fwd_z,
    input  logic [fcd_pkg::SPD_W-1:0]         speed,
    input  logic [fcd_pkg::TIME_W-1:0]        stamp,
    input  logic                              last,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [fcd_pkg::VEC_W-1:0]  dir_x,
    input  logic signed [fcd_pkg::VEC_W-1:0]  dir_y,
    input  logic [fcd_pkg::DIRZ_W-1:0]        dir_z,
    output int                                fail_count,
    output int                                pending_dirs
);
    import fcd_pkg::*;

    localparam longint SIXTY_FOUR_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SIXTY_FOUR_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [DIRZ_W-1:0]       z;
    } steer_dir_t;

    steer_dir_t            dir_queue[$];
    longint                ego_px, ego_py, ego_f[3];
    logic [TIME_W-1:0]     ego_now;
    longint                lateral_sum;
    int unsigned           hit_count;
    logic [DIST_W-1:0]     radius;

    // shift = f * spd * age / 16384000, halves away from zero
    function automatic longint drift(longint f, longint spd, longint age);
        logic [127:0] m;
        longint q;
        m = 128'(f < 0 ? -f : f) * 128'(spd) * 128'(age < 0 ? -age : age);
        q = longint'((m + 128'd8192000) / 128'd16384000);
        return ((f < 0) != (age < 0)) ? -q : q;
    endfunction

    function automatic longint unit_mag(longint c, longint l2);
        logic [127:0] rhs, t;
        longint lo, hi, mid;
        rhs = 128'(c < 0 ? -c : c) ** 2 * (128'd1 << 30);
        lo = 0;
        hi = 16384;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 128'(2 * mid - 1);
            if (t * t * 128'(l2) <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return c < 0 ? -lo : lo;
    endfunction

    task automatic take_item();
        longint age, dx, dy, fdot, proj, sx, sy, l2, ox, oy;
        logic [127:0] d2;
        steer_dir_t d;
        if (mode == 1'b0)
        begin
            ego_px = pos_x;
            ego_py = pos_y;
            ego_f[0] = fwd_x;
            ego_f[1] = fwd_y;
            ego_f[2] = fwd_z;
            ego_now = stamp;
            lateral_sum = 0;
            hit_count = 0;
        end
        else
        begin
            age = longint'(ego_now) - longint'(stamp);
            dx = longint'(pos_x) + drift(fwd_x, speed, age) - ego_px;
            dy = longint'(pos_y) + drift(fwd_y, speed, age) - ego_py;
            fdot = ego_f[0] * fwd_x + ego_f[1] * fwd_y + ego_f[2] * fwd_z;
            if (dx > -(64'sd1 << 25) && dx < (64'sd1 << 25) && dy > -(64'sd1 << 25)
                && dy < (64'sd1 << 25) && fdot > 0)
            begin
                d2 = 128'(dx * dx) + 128'(dy * dy);
                if (d2 < 128'(radius) * 128'(radius))
                begin
                    proj = dx * (-ego_f[1]) + dy * ego_f[0];
                    if (proj > 0 && lateral_sum > SIXTY_FOUR_MAX - proj)
                        lateral_sum = SIXTY_FOUR_MAX;
                    else if (proj < 0 && lateral_sum < SIXTY_FOUR_MIN - proj)
                        lateral_sum = SIXTY_FOUR_MIN;
                    else
                        lateral_sum += proj;
                    if (hit_count < 65535) hit_count++;
                end
            end
        end
        if (last)
        begin
            ox = 0;
            oy = 0;
            d.z = '0;
            if (hit_count == 0)
                d.z = UP_Z;
            else
            begin
                sx = -ego_f[1];
                sy = ego_f[0];
                l2 = sx * sx + sy * sy;
                if (lateral_sum != 0 && l2 != 0)
                begin
                    ox = unit_mag(sx, l2);
                    oy = unit_mag(sy, l2);
                    if (lateral_sum < 0)
                    begin
                        ox = -ox;
                        oy = -oy;
                    end
                end
            end
            d.x = ox[VEC_W-1:0];
            d.y = oy[VEC_W-1:0];
            dir_queue.push_back(d);
            lateral_sum = 0;
            hit_count = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        steer_dir_t e;
        if (!rst_n)
        begin
            ego_px = 0;
            ego_py = 0;
            ego_f = '{0, 0, 0};
            ego_now = '0;
            lateral_sum = 0;
            hit_count = 0;
            radius = MAX_DIST_RST;
            fail_count = 0;
            dir_queue.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (dir_queue.size() == 0)
                begin
                    $error("unexpected result transaction");
                    fail_count++;
                end
                else
                begin
                    e = dir_queue.pop_front();
                    if (dir_x !== e.x)
                    begin
                        $error("dir_x expected %0d actual %0d", e.x, dir_x);
                        fail_count++;
                    end
                    if (dir_y !== e.y)
                    begin
                        $error("dir_y expected %0d actual %0d", e.y, dir_y);
                        fail_count++;
                    end
                    if (dir_z !== e.z)
                    begin
                        $error("dir_z expected %0d actual %0d", e.z, dir_z);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en) radius = cfg_wr_data;
            if (in_valid && !in_stall) take_item();
        end
        pending_dirs = dir_queue.size();
    end
endmodule

// ===== dv/flock_cohesion_direction_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flock_cohesion_direction_test
// Drives ego/neighbor jobs through the cohesion block under random bursts
// and output stalls across several radius settings; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module flock_cohesion_direction_test;
    import fcd_pkg::*;

    localparam logic MODE_EGO      = 1'b0;
    localparam logic MODE_NEIGHBOR = 1'b1;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [DIST_W-1:0]          cfg_wr_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       mode = 1'b0;
    logic signed [POS_W-1:0]    pos_x = '0, pos_y = '0;
    logic signed [VEC_W-1:0]    fwd_x = '0, fwd_y = '0, fwd_z = '0;
    logic [SPD_W-1:0]           speed = '0;
    logic [TIME_W-1:0]          stamp = '0;
    logic                       last = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [VEC_W-1:0]    dir_x, dir_y;
    logic [DIRZ_W-1:0]          dir_z;
    int                         fail_count;
    int                         pending_dirs;

    // current ego, so neighbors can be placed near it
    logic signed [31:0]         ego_x_now, ego_y_now;
    logic [31:0]                now_ms;
    logic signed [15:0]         efx, efy, efz;
    logic [DIST_W-1:0]          radius_now;
    int                         stall_style = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    flock_cohesion_direction dut (.*);

    flock_cohesion_direction_checker checker_i (.*);

    // Receiver stall pattern: mode changes now and then; mode 0 never stalls.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0) stall_style <= $urandom_range(0, 3);
        case (stall_style)
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            3: out_stall <= ($urandom_range(0, 9) != 0);
            default: out_stall <= 1'b0;
        endcase
    end

    // Hand one transaction to the block and hold it until accepted.
    task automatic send_item(logic m, logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [15:0] fx, logic signed [15:0] fy,
                             logic signed [15:0] fz, logic [15:0] spd,
                             logic [31:0] st, logic lst);
        in_valid <= 1'b1;
        mode <= m;
        pos_x <= px;
        pos_y <= py;
        fwd_x <= fx;
        fwd_y <= fy;
        fwd_z <= fz;
        speed <= spd;
        stamp <= st;
        last <= lst;
        do @(posedge clk); while (in_stall);
    endtask

    // Gap between bursts; drops valid only when a gap is taken.
    task automatic maybe_gap();
        int n;
        if ($urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic signed [15:0] rand_vec();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic send_ego(logic lst);
        ego_x_now = $urandom_range(0, 3) == 0 ? 32'($urandom)
                                              : 32'($signed($urandom_range(0, 200000)) - 100000);
        ego_y_now = $urandom_range(0, 3) == 0 ? 32'($urandom)
                                              : 32'($signed($urandom_range(0, 200000)) - 100000);
        efx = rand_vec();
        efy = rand_vec();
        efz = rand_vec();
        if ($urandom_range(0, 15) == 0)
        begin
            efx = 0;
            efy = 0;
        end
        now_ms = $urandom;
        send_item(MODE_EGO, ego_x_now, ego_y_now, efx, efy, efz,
                  16'($urandom), now_ms, lst);
    endtask

    // Neighbor mostly near the ego and heading roughly the same way.
    task automatic send_neighbor(logic lst);
        logic signed [31:0] span, px, py;
        logic signed [15:0] fx, fy, fz;
        logic [31:0] st;
        span = (radius_now == 0) ? 32'sd16 : 32'(radius_now) + 32'sd16;
        if (span > 32'sd40000000) span = 32'sd40000000;
        if ($urandom_range(0, 7) == 0)
        begin
            px = $urandom;
            py = $urandom;
        end
        else
        begin
            px = ego_x_now + $signed($urandom_range(0, 2 * span)) - span;
            py = ego_y_now + $signed($urandom_range(0, 2 * span)) - span;
        end
        if ($urandom_range(0, 4) == 0)
        begin
            fx = rand_vec();
            fy = rand_vec();
            fz = rand_vec();
        end
        else
        begin
            fx = efx + $signed(16'($urandom_range(0, 400))) - 16'sd200;
            fy = efy + $signed(16'($urandom_range(0, 400))) - 16'sd200;
            fz = efz;
        end
        case ($urandom_range(0, 4))
            0: st = $urandom;
            1: st = now_ms;
            default: st = now_ms - $urandom_range(0, 2000) + 500;
        endcase
        send_item(MODE_NEIGHBOR, px, py, fx, fy, fz,
                  $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8000)),
                  st, lst);
    endtask

    // Quiet point: everything drained, then margin for an unfinished item.
    task automatic write_radius(logic [DIST_W-1:0] r);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_dirs != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= r;
        radius_now = r;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int n, k;
        logic [DIST_W-1:0] radii[6];
        radius_now = MAX_DIST_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: neighbor before any ego, lone ego job, extremes.
        send_item(MODE_NEIGHBOR, 32'sd100, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 32'd0, 1'b1);
        send_item(MODE_EGO, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd0, 32'd1000, 1'b1);
        send_item(MODE_EGO, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd0, 32'd1000, 1'b0);
        send_item(MODE_NEIGHBOR, 32'sd0, 32'sd100, 16'sd16384, 16'sd0, 16'sd0,
                  16'd0, 32'd1000, 1'b0);
        send_item(MODE_NEIGHBOR, 32'sd0, -32'sd100, 16'sd16384, 16'sd0, 16'sd0,
                  16'd0, 32'd1000, 1'b1);                     // zero sum
        send_item(MODE_EGO, 32'h7FFF_FFFF, 32'h8000_0000, -16'sd16384, 16'sh7FFF,
                  16'sh8000, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(MODE_NEIGHBOR, 32'h8000_0000, 32'h7FFF_FFFF, 16'sh8000, 16'sh7FFF,
                  16'sh7FFF, 16'hFFFF, 32'd0, 1'b0);
        send_item(MODE_NEIGHBOR, 32'h7FFF_FFF0, 32'h8000_0010, -16'sd16384, 16'sd16384,
                  16'sh8000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(MODE_EGO, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd16384,
                  16'd0, 32'd0, 1'b0);                        // degenerate side axis
        send_item(MODE_NEIGHBOR, 32'sd50, 32'sd50, 16'sd0, 16'sd0, 16'sd16384,
                  16'd0, 32'd0, 1'b1);
        send_item(MODE_EGO, 32'sd0, 32'sd0, 16'sd11585, 16'sd11585, 16'sd0,
                  16'd0, 32'd5000, 1'b0);
        send_item(MODE_NEIGHBOR, -32'sd300, 32'sd400, 16'sd11585, 16'sd11585, 16'sd0,
                  16'd65535, 32'd4000, 1'b1);                 // future/past extrapolation

        radii = '{24'd0, 24'd1, 24'hFF_FFFF, 24'd12800, 24'd300000, 24'd2000};
        foreach (radii[i])
        begin
            write_radius(radii[i]);
            n = 0;
            while (n < 210)
            begin
                k = $urandom_range(0, 6);
                send_ego(k == 0);
                n++;
                for (int j = 0; j < k; j++)
                begin
                    maybe_gap();
                    // occasionally a stray ego restarts the job mid-stream
                    if ($urandom_range(0, 30) == 0) send_ego(j == k - 1);
                    else send_neighbor(j == k - 1);
                    n++;
                end
                maybe_gap();
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_dirs != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending_dirs == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/fcd_pkg.sv
hw/rtl/fcd_ctrl.sv
hw/rtl/fcd_dp.sv
hw/rtl/flock_cohesion_direction.sv
hw/rtl/fcd_checker.sv
dv/flock_cohesion_direction_checker.sv
dv/flock_cohesion_direction_test.sv
